// File: design/psms_pkg.sv
// shared types and constants for the power switch mode supervisor
package psms_pkg;

  typedef enum logic [1:0] {
    OP_GUARD    = 2'd0,
    OP_SERVICE  = 2'd1,
    OP_IRQ      = 2'd2,
    OP_BUSINESS = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REQ_NONE     = 2'd0,
    REQ_POWEROFF = 2'd1,
    REQ_MODE     = 2'd2,
    REQ_RESET    = 2'd3
  } request_e;

  typedef enum logic [1:0] {
    MODE_BT          = 2'd0,
    MODE_PC          = 2'd1,
    MODE_IDLE_CHARGE = 2'd2,
    MODE_UNUSED      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MAX_ATTEMPTS  = 3'd0,
    CFG_RETRY_DELAY   = 3'd1,
    CFG_SHUTDOWN_DL   = 3'd2,
    CFG_OFF_CONFIRM   = 3'd3,
    CFG_PC_SERVICE_EN = 3'd4,
    CFG_DEVICE_ROLE   = 3'd5,
    CFG_RSVD6         = 3'd6,
    CFG_RSVD7         = 3'd7
  } cfg_idx_e;

  localparam logic [3:0] MAX_ATTEMPTS_RST  = 4'd3;
  localparam logic [7:0] RETRY_DELAY_RST   = 8'd10;
  localparam logic [7:0] SHUTDOWN_DL_RST   = 8'd30;
  localparam logic [3:0] OFF_CONFIRM_RST   = 4'd2;
  localparam logic       PC_SERVICE_RST    = 1'b1;
  localparam logic [2:0] DEVICE_ROLE_RST   = 3'd1;

  typedef struct packed {
    logic [3:0] max_attempts;
    logic [7:0] retry_delay;
    logic [7:0] shutdown_deadline;
    logic [3:0] off_confirm_count;
    logic       pc_service_enable;
    logic [2:0] device_role_code;
  } cfg_t;

  typedef struct packed {
    opcode_e    opcode;
    logic       switch_on;
    logic       vbus_present;
    logic [2:0] usb_state;
    logic       app_business_started;
    logic       poweroff_in_progress;
    logic       in_pc_mode;
    logic       in_idle_mode;
  } item_t;

  typedef struct packed {
    request_e request;
    mode_e    target_mode;
    logic     edge_update;
    logic     edge_rising;
    logic     storage_service;
    logic     shutdown_latched;
    logic     sleep_allowed;
  } result_t;

endpackage

// File: design/psms_cfg_regs.sv
// configuration register file of the supervisor
module psms_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_addr_i,
  input  logic [7:0]           cfg_data_i,
  output psms_pkg::cfg_t       cfg_o
);

  psms_pkg::cfg_t cfg_q;
  psms_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (psms_pkg::cfg_idx_e'(cfg_addr_i))
        psms_pkg::CFG_MAX_ATTEMPTS:  cfg_d.max_attempts      = cfg_data_i[3:0];
        psms_pkg::CFG_RETRY_DELAY:   cfg_d.retry_delay       = cfg_data_i;
        psms_pkg::CFG_SHUTDOWN_DL:   cfg_d.shutdown_deadline = cfg_data_i;
        psms_pkg::CFG_OFF_CONFIRM:   cfg_d.off_confirm_count = cfg_data_i[3:0];
        psms_pkg::CFG_PC_SERVICE_EN: cfg_d.pc_service_enable = cfg_data_i[0];
        psms_pkg::CFG_DEVICE_ROLE:   cfg_d.device_role_code  = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts      <= psms_pkg::MAX_ATTEMPTS_RST;
      cfg_q.retry_delay       <= psms_pkg::RETRY_DELAY_RST;
      cfg_q.shutdown_deadline <= psms_pkg::SHUTDOWN_DL_RST;
      cfg_q.off_confirm_count <= psms_pkg::OFF_CONFIRM_RST;
      cfg_q.pc_service_enable <= psms_pkg::PC_SERVICE_RST;
      cfg_q.device_role_code  <= psms_pkg::DEVICE_ROLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/psms_engine.sv
// supervisor state and the per-event decision logic
module psms_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  psms_pkg::cfg_t    cfg_i,
  input  psms_pkg::item_t   item_i,
  output psms_pkg::result_t result_o
);

  logic [3:0] off_cnt_q, off_cnt_d;
  logic [7:0] dl_cnt_q, dl_cnt_d;
  logic       sd_q, sd_d;
  logic       irq_q, irq_d;
  logic       bus_q, bus_d;
  logic       prior_vld_q, prior_vld_d;
  logic       prior_lvl_q, prior_lvl_d;
  logic       last_vld_q, last_vld_d;
  logic [4:0] last_q, last_d;
  logic [3:0] att_q, att_d;
  logic [7:0] rty_q, rty_d;

  logic [4:0] off_next;
  logic [4:0] cur_inputs;
  logic       changed;
  logic [3:0] att_eff;
  logic [7:0] rty_eff;
  logic       cold;
  logic       have;
  psms_pkg::mode_e    target;
  psms_pkg::result_t  res;

  assign off_next   = {1'b0, off_cnt_q} + 5'd1;
  assign cur_inputs = {item_i.switch_on, item_i.vbus_present, item_i.usb_state};
  assign changed    = !last_vld_q || (last_q != cur_inputs);
  assign att_eff    = changed ? 4'd0 : att_q;
  assign rty_eff    = changed ? 8'd0 : rty_q;
  assign cold       = !bus_q && !item_i.app_business_started;

  // mode target selection for a service request
  always_comb begin
    have   = 1'b0;
    target = psms_pkg::MODE_BT;
    if (item_i.switch_on) begin
      have = item_i.in_pc_mode || item_i.in_idle_mode;
    end else if (cfg_i.pc_service_enable && (item_i.usb_state == cfg_i.device_role_code)) begin
      have   = !item_i.in_pc_mode;
      target = psms_pkg::MODE_PC;
    end else begin
      have   = item_i.in_pc_mode;
      target = psms_pkg::MODE_IDLE_CHARGE;
    end
  end

  always_comb begin
    off_cnt_d   = off_cnt_q;
    dl_cnt_d    = dl_cnt_q;
    sd_d        = sd_q;
    irq_d       = irq_q;
    bus_d       = bus_q;
    prior_vld_d = prior_vld_q;
    prior_lvl_d = prior_lvl_q;
    last_vld_d  = last_vld_q;
    last_d      = last_q;
    att_d       = att_q;
    rty_d       = rty_q;
    res                  = '0;
    res.request          = psms_pkg::REQ_NONE;
    res.target_mode      = psms_pkg::MODE_BT;

    case (item_i.opcode)
      psms_pkg::OP_GUARD: begin
        if (!sd_q) begin
          if (item_i.switch_on) begin
            off_cnt_d = 4'd0;
            irq_d     = 1'b0;
          end else if (off_next >= {1'b0, cfg_i.off_confirm_count}) begin
            off_cnt_d = cfg_i.off_confirm_count;
            irq_d     = 1'b0;
            if (bus_q || !item_i.vbus_present) begin
              sd_d = 1'b1;
            end
          end else begin
            off_cnt_d = off_next[3:0];
          end
        end
        if (sd_d) begin
          if (dl_cnt_q != 8'hFF) begin
            dl_cnt_d = dl_cnt_q + 8'd1;
          end
          if (dl_cnt_d >= cfg_i.shutdown_deadline) begin
            res.request = psms_pkg::REQ_RESET;
          end
        end
      end
      psms_pkg::OP_IRQ: begin
        irq_d = 1'b1;
      end
      psms_pkg::OP_BUSINESS: begin
        bus_d = 1'b1;
      end
      default: begin
        if (!prior_vld_q || (prior_lvl_q != item_i.switch_on)) begin
          prior_vld_d = 1'b1;
          prior_lvl_d = item_i.switch_on;
        end else begin
          res.edge_update = 1'b1;
          res.edge_rising = item_i.switch_on;
          att_d      = att_eff;
          rty_d      = rty_eff;
          last_vld_d = 1'b1;
          last_d     = cur_inputs;
          if (item_i.poweroff_in_progress) begin
            // bookkeeping only
          end else if (sd_q || (!item_i.switch_on && (!cold || !item_i.vbus_present))) begin
            sd_d        = 1'b1;
            res.request = psms_pkg::REQ_POWEROFF;
          end else begin
            res.storage_service = 1'b1;
            if (rty_eff != 8'd0) begin
              rty_d = rty_eff - 8'd1;
            end else if ((att_eff < cfg_i.max_attempts) && have) begin
              att_d           = att_eff + 4'd1;
              rty_d           = cfg_i.retry_delay;
              res.request     = psms_pkg::REQ_MODE;
              res.target_mode = target;
            end
          end
        end
      end
    endcase

    res.shutdown_latched = sd_d;
    res.sleep_allowed    = !sd_d && !irq_d &&
                           (item_i.switch_on || (!bus_d && item_i.vbus_present));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_cnt_q   <= 4'd0;
      dl_cnt_q    <= 8'd0;
      sd_q        <= 1'b0;
      irq_q       <= 1'b0;
      bus_q       <= 1'b0;
      prior_vld_q <= 1'b0;
      prior_lvl_q <= 1'b0;
      last_vld_q  <= 1'b0;
      last_q      <= 5'd0;
      att_q       <= 4'd0;
      rty_q       <= 8'd0;
    end else if (step_i) begin
      off_cnt_q   <= off_cnt_d;
      dl_cnt_q    <= dl_cnt_d;
      sd_q        <= sd_d;
      irq_q       <= irq_d;
      bus_q       <= bus_d;
      prior_vld_q <= prior_vld_d;
      prior_lvl_q <= prior_lvl_d;
      last_vld_q  <= last_vld_d;
      last_q      <= last_d;
      att_q       <= att_d;
      rty_q       <= rty_d;
    end
  end

  assign result_o = res;

  // shutdown latch never drops once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) sd_q |=> sd_q)
    else $error("shutdown latch cleared");

  // attempts stay within the configured budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.request == psms_pkg::REQ_MODE) |-> (att_d <= cfg_i.max_attempts))
    else $error("mode attempt budget exceeded");

  // a cpu reset is only asked for with the latch set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.request == psms_pkg::REQ_RESET) |-> sd_d)
    else $error("cpu reset without shutdown latch");

endmodule

// File: design/power_switch_mode_supervisor.sv
// top level of the power switch mode supervisor
// Usage: each request on the slave stream is one event (tuser = event kind,
// tdata = sampled switch, supply and application status). Every event yields
// exactly one result on the master stream (tuser = request code, tdata = mode
// target, wake edge re-arm, storage service, shutdown latch, sleep allowed).
// Events pass an input register, then the decision logic, then the result
// register: tvalid rises once the result register is loaded from an accepted
// event, which waits while a result is stalled, and one event is taken every
// cycle while the result side keeps up.
// When the receiver stalls, the result register holds and the input register
// takes one more event; the slave tready drops only when both are full.
// The configuration channel is always ready and updates one register per
// write; writes are expected only while no event is in flight.
// Reset clears all supervisor state, empties both registers and loads the
// configuration defaults (3 attempts, delay 10, deadline 30, confirm 2,
// pc service on, device role code 1).
module power_switch_mode_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // switch_on, vbus_present, usb_state[2:0], app_business_started,
  // poweroff_in_progress, in_pc_mode, in_idle_mode, zero fill
  input  logic [15:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // target_mode[1:0], edge_update, edge_rising, storage_service,
  // shutdown_latched, sleep_allowed, zero fill
  output logic [7:0]  m_axis_tdata_o,
  // request[1:0]
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  psms_pkg::cfg_t    cfg;
  psms_pkg::item_t   item_q;
  psms_pkg::result_t res, res_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              step;
  logic              in_ready;

  assign step     = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign in_ready = !in_vld_q || step;

  psms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  psms_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      item_q.opcode               <= psms_pkg::opcode_e'(s_axis_tuser_i);
      item_q.switch_on            <= s_axis_tdata_i[0];
      item_q.vbus_present         <= s_axis_tdata_i[1];
      item_q.usb_state            <= s_axis_tdata_i[4:2];
      item_q.app_business_started <= s_axis_tdata_i[5];
      item_q.poweroff_in_progress <= s_axis_tdata_i[6];
      item_q.in_pc_mode           <= s_axis_tdata_i[7];
      item_q.in_idle_mode         <= s_axis_tdata_i[8];
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.request;
  assign m_axis_tdata_o  = {1'b0, res_q.sleep_allowed, res_q.shutdown_latched,
                            res_q.storage_service, res_q.edge_rising,
                            res_q.edge_update, res_q.target_mode};

  // input side stalls only when both registers are occupied and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  // a rising wake edge is reported only together with a re-arm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.edge_rising |-> res_q.edge_update)
    else $error("edge polarity without re-arm");

  // storage service goes only with no request or a mode request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.storage_service |->
      (res_q.request == psms_pkg::REQ_NONE) || (res_q.request == psms_pkg::REQ_MODE))
    else $error("storage service with power request");

endmodule

// File: test/tb.sv
// self-checking testbench for the power switch mode supervisor
`timescale 1ns / 1ps

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_data = '0;

  power_switch_mode_supervisor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // supervisor shadow: configuration and state
  psms_pkg::cfg_t cfg_shadow = '{psms_pkg::MAX_ATTEMPTS_RST, psms_pkg::RETRY_DELAY_RST,
                                 psms_pkg::SHUTDOWN_DL_RST, psms_pkg::OFF_CONFIRM_RST,
                                 psms_pkg::PC_SERVICE_RST, psms_pkg::DEVICE_ROLE_RST};
  logic [3:0] off_run = '0;
  logic [7:0] deadline_run = '0;
  logic       shutdown_pend = 1'b0;
  logic       wake_irq = 1'b0;
  logic       biz_mode = 1'b0;
  logic       level_seen = 1'b0;
  logic       level_prev = 1'b0;
  logic       snap_seen = 1'b0;
  logic [4:0] snap_prev = '0;
  logic [3:0] attempts_used = '0;
  logic [7:0] retry_wait = '0;

  psms_pkg::result_t pending_results[$];
  int      errors = 0;
  int      events_sent = 0;
  int      results_seen = 0;
  int      mode_requests = 0;
  int      cpu_resets = 0;
  int      poweroff_requests = 0;

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL power_switch_mode_supervisor");
    $finish;
  end

  // sender burst control and sticky input environment
  int         burst_left = 0;
  logic       env_on = 1'b1;
  logic       env_vbus = 1'b1;
  logic [2:0] env_usb = 3'd0;

  function automatic psms_pkg::result_t supervise_event(psms_pkg::item_t ev);
    psms_pkg::result_t r;
    logic [4:0] next_off;
    logic [4:0] cur;
    logic       cold;
    logic       have;
    r = '0;
    r.request = psms_pkg::REQ_NONE;
    r.target_mode = psms_pkg::MODE_BT;
    case (ev.opcode)
      psms_pkg::OP_GUARD: begin
        if (!shutdown_pend) begin
          if (ev.switch_on) begin
            off_run = '0;
            wake_irq = 1'b0;
          end else begin
            next_off = {1'b0, off_run} + 5'd1;
            if (next_off >= {1'b0, cfg_shadow.off_confirm_count}) begin
              off_run = cfg_shadow.off_confirm_count;
              wake_irq = 1'b0;
              if (biz_mode || !ev.vbus_present) shutdown_pend = 1'b1;
            end else begin
              off_run = next_off[3:0];
            end
          end
        end
        if (shutdown_pend) begin
          if (deadline_run != 8'hff) deadline_run = deadline_run + 8'd1;
          if (deadline_run >= cfg_shadow.shutdown_deadline) r.request = psms_pkg::REQ_RESET;
        end
      end
      psms_pkg::OP_IRQ: wake_irq = 1'b1;
      psms_pkg::OP_BUSINESS: biz_mode = 1'b1;
      default: begin
        if (!level_seen || level_prev != ev.switch_on) begin
          level_seen = 1'b1;
          level_prev = ev.switch_on;
        end else begin
          cur = {ev.switch_on, ev.vbus_present, ev.usb_state};
          cold = !biz_mode && !ev.app_business_started;
          r.edge_update = 1'b1;
          r.edge_rising = ev.switch_on;
          if (!snap_seen || snap_prev != cur) begin
            attempts_used = '0;
            retry_wait = '0;
          end
          snap_seen = 1'b1;
          snap_prev = cur;
          if (ev.poweroff_in_progress) begin
          end else if (shutdown_pend || (!ev.switch_on && (!cold || !ev.vbus_present))) begin
            shutdown_pend = 1'b1;
            r.request = psms_pkg::REQ_POWEROFF;
          end else begin
            r.storage_service = 1'b1;
            have = 1'b0;
            if (retry_wait != 8'd0) begin
              retry_wait = retry_wait - 8'd1;
            end else if (attempts_used < cfg_shadow.max_attempts) begin
              if (ev.switch_on) begin
                if (ev.in_pc_mode || ev.in_idle_mode) begin
                  r.target_mode = psms_pkg::MODE_BT;
                  have = 1'b1;
                end
              end else if (cfg_shadow.pc_service_enable &&
                           ev.usb_state == cfg_shadow.device_role_code) begin
                if (!ev.in_pc_mode) begin
                  r.target_mode = psms_pkg::MODE_PC;
                  have = 1'b1;
                end
              end else if (ev.in_pc_mode) begin
                r.target_mode = psms_pkg::MODE_IDLE_CHARGE;
                have = 1'b1;
              end
              if (have) begin
                attempts_used = attempts_used + 4'd1;
                retry_wait = cfg_shadow.retry_delay;
                r.request = psms_pkg::REQ_MODE;
              end
            end
          end
        end
      end
    endcase
    r.shutdown_latched = shutdown_pend;
    r.sleep_allowed = !shutdown_pend && !wake_irq &&
                      (ev.switch_on || (!biz_mode && ev.vbus_present));
    return r;
  endfunction

  function automatic psms_pkg::item_t ev(psms_pkg::opcode_e op, logic on, logic vbus,
                                         logic [2:0] usb, logic app, logic po, logic pc,
                                         logic idle);
    psms_pkg::item_t e;
    e.opcode = op;
    e.switch_on = on;
    e.vbus_present = vbus;
    e.usb_state = usb;
    e.app_business_started = app;
    e.poweroff_in_progress = po;
    e.in_pc_mode = pc;
    e.in_idle_mode = idle;
    return e;
  endfunction

  // random event over a slowly changing environment; when latching is not
  // wanted, an event that would latch shutdown is moved to switch on
  function automatic psms_pkg::item_t random_event(logic allow_biz, logic allow_latch,
                                                   int guard_pct);
    psms_pkg::item_t e;
    int    pick;
    if ($urandom_range(0, 9) == 0) env_on = ~env_on;
    if ($urandom_range(0, 11) == 0) env_vbus = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 11) == 0)
      env_usb = $urandom_range(0, 1) ? cfg_shadow.device_role_code : 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < guard_pct) e.opcode = psms_pkg::OP_GUARD;
    else if (pick < 85) e.opcode = psms_pkg::OP_SERVICE;
    else if (pick < 93 || !allow_biz) e.opcode = psms_pkg::OP_IRQ;
    else e.opcode = psms_pkg::OP_BUSINESS;
    e.switch_on = env_on;
    e.vbus_present = env_vbus;
    e.usb_state = env_usb;
    e.app_business_started = ($urandom_range(0, 3) == 0);
    e.poweroff_in_progress = ($urandom_range(0, 9) == 0);
    e.in_pc_mode = ($urandom_range(0, 9) < 4);
    e.in_idle_mode = ($urandom_range(0, 9) < 3);
    if (!allow_latch && !shutdown_pend && !e.switch_on) begin
      if (e.opcode == psms_pkg::OP_GUARD &&
          ({1'b0, off_run} + 5'd1 >= {1'b0, cfg_shadow.off_confirm_count}) &&
          (biz_mode || !e.vbus_present))
        e.switch_on = 1'b1;
      if (e.opcode == psms_pkg::OP_SERVICE && level_seen && !level_prev &&
          !e.poweroff_in_progress &&
          (biz_mode || e.app_business_started || !e.vbus_present))
        e.switch_on = 1'b1;
    end
    return e;
  endfunction

  task automatic send_event(psms_pkg::item_t e);
    psms_pkg::result_t r;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= e.opcode;
    s_axis_tdata <= {7'b0, e.in_idle_mode, e.in_pc_mode, e.poweroff_in_progress,
                     e.app_business_started, e.usb_state, e.vbus_present, e.switch_on};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = supervise_event(e);
    pending_results.push_back(r);
    events_sent++;
    burst_left--;
    case (r.request)
      psms_pkg::REQ_MODE: mode_requests++;
      psms_pkg::REQ_RESET: cpu_resets++;
      psms_pkg::REQ_POWEROFF: poweroff_requests++;
      default: ;
    endcase
  endtask

  task automatic send_random(int count, logic allow_biz, logic allow_latch, int guard_pct);
    repeat (count) send_event(random_event(allow_biz, allow_latch, guard_pct));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(psms_pkg::cfg_idx_e idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      psms_pkg::CFG_MAX_ATTEMPTS:  cfg_shadow.max_attempts = val[3:0];
      psms_pkg::CFG_RETRY_DELAY:   cfg_shadow.retry_delay = val;
      psms_pkg::CFG_SHUTDOWN_DL:   cfg_shadow.shutdown_deadline = val;
      psms_pkg::CFG_OFF_CONFIRM:   cfg_shadow.off_confirm_count = val[3:0];
      psms_pkg::CFG_PC_SERVICE_EN: cfg_shadow.pc_service_enable = val[0];
      psms_pkg::CFG_DEVICE_ROLE:   cfg_shadow.device_role_code = val[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [3:0] att, logic [7:0] dly, logic [7:0] dl,
                           logic [3:0] conf, logic pc_en, logic [2:0] role);
    write_reg(psms_pkg::CFG_MAX_ATTEMPTS, {4'b0, att});
    write_reg(psms_pkg::CFG_RETRY_DELAY, dly);
    write_reg(psms_pkg::CFG_SHUTDOWN_DL, dl);
    write_reg(psms_pkg::CFG_OFF_CONFIRM, {4'b0, conf});
    write_reg(psms_pkg::CFG_PC_SERVICE_EN, {7'b0, pc_en});
    write_reg(psms_pkg::CFG_DEVICE_ROLE, {5'b0, role});
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch in result %0d: %s got %0d expected %0d", results_seen, field, got, want);
    errors++;
  endtask

  // receiver: checks each result and redraws its stall pattern when a run ends
  int rx_mode = 0;
  int rx_left = 0;
  int rx_period = 1;
  int rx_tick = 0;

  always @(posedge clk_i) begin
    psms_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("result with nothing expected, request %0d", m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.request)
          report_mismatch("request", m_axis_tuser, want.request);
        if (m_axis_tdata[1:0] != want.target_mode)
          report_mismatch("target_mode", m_axis_tdata[1:0], want.target_mode);
        if (m_axis_tdata[2] != want.edge_update)
          report_mismatch("edge_update", m_axis_tdata[2], want.edge_update);
        if (m_axis_tdata[3] != want.edge_rising)
          report_mismatch("edge_rising", m_axis_tdata[3], want.edge_rising);
        if (m_axis_tdata[4] != want.storage_service)
          report_mismatch("storage_service", m_axis_tdata[4], want.storage_service);
        if (m_axis_tdata[5] != want.shutdown_latched)
          report_mismatch("shutdown_latched", m_axis_tdata[5], want.shutdown_latched);
        if (m_axis_tdata[6] != want.sleep_allowed)
          report_mismatch("sleep_allowed", m_axis_tdata[6], want.sleep_allowed);
      end
      results_seen++;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
      rx_period = $urandom_range(1, 8);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rx_tick / rx_period) % 2 == 0);
    endcase
  end

  task automatic test_directed_modes;
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd0, 0, 0, 1, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd0, 0, 0, 1, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd0, 0, 0, 1, 0));
    send_event(ev(psms_pkg::OP_IRQ, 1, 1, 3'd0, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_GUARD, 1, 1, 3'd0, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_GUARD, 0, 1, 3'd0, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_GUARD, 0, 1, 3'd0, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd1, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd1, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd0, 0, 0, 1, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd0, 0, 1, 1, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd7, 1, 1, 1, 1));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd7, 1, 0, 1, 1));
    send_event(ev(psms_pkg::OP_GUARD, 1, 1, 3'd7, 1, 1, 1, 1));
    drain();
  endtask

  task automatic test_config_extremes;
    write_reg(psms_pkg::CFG_MAX_ATTEMPTS, 8'd0);
    send_event(ev(psms_pkg::OP_SERVICE, 1, 0, 3'd2, 0, 0, 1, 1));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 0, 3'd2, 0, 0, 1, 1));
    drain();
    write_reg(psms_pkg::CFG_OFF_CONFIRM, 8'd0);
    send_event(ev(psms_pkg::OP_GUARD, 0, 1, 3'd1, 0, 0, 0, 0));
    drain();
    write_reg(psms_pkg::CFG_MAX_ATTEMPTS, 8'd15);
    write_reg(psms_pkg::CFG_RETRY_DELAY, 8'd0);
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd1, 0, 0, 0, 1));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd1, 0, 0, 0, 1));
    send_event(ev(psms_pkg::OP_SERVICE, 0, 1, 3'd1, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_cold;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0: write_all(4'd1, 8'd0, 8'd30, 4'd1, 1'b1, 3'($urandom_range(0, 7)));
        1: write_all(4'd15, 8'd255, 8'd255, 4'd15, 1'b0, 3'($urandom_range(0, 7)));
        2: write_all(4'd3, 8'd10, 8'd1, 4'd0, 1'b1, 3'd0);
        3: write_all(4'd0, 8'd2, 8'd100, 4'd2, 1'b1, 3'd7);
        default: write_all(4'($urandom_range(1, 15)), 8'($urandom_range(0, 4)),
                           8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
                           1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      endcase
      send_random(120, 1'b0, 1'b0, 40);
      drain();
    end
  endtask

  task automatic test_business_mode;
    write_all(4'($urandom_range(1, 15)), 8'($urandom_range(0, 3)), 8'd200, 4'd15,
              1'b1, 3'($urandom_range(0, 7)));
    send_event(ev(psms_pkg::OP_BUSINESS, 1, 0, 3'd3, 1, 0, 0, 1));
    send_random(250, 1'b1, 1'b0, 40);
    drain();
    write_all(4'd2, 8'd1, 8'd50, 4'd4, 1'b0, 3'($urandom_range(0, 7)));
    send_random(250, 1'b1, 1'b0, 40);
    drain();
  endtask

  task automatic test_shutdown;
    write_all(4'd3, 8'd0, 8'd0, 4'd1, 1'b1, 3'd1);
    send_event(ev(psms_pkg::OP_GUARD, 0, 0, 3'd1, 0, 0, 0, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd1, 0, 0, 1, 0));
    send_event(ev(psms_pkg::OP_SERVICE, 1, 1, 3'd1, 0, 0, 1, 0));
    drain();
    write_reg(psms_pkg::CFG_SHUTDOWN_DL, 8'd255);
    send_random(520, 1'b1, 1'b1, 55);
    drain();
    write_reg(psms_pkg::CFG_SHUTDOWN_DL, 8'd20);
    send_random(90, 1'b1, 1'b1, 50);
    drain();
    write_reg(psms_pkg::CFG_SHUTDOWN_DL, 8'd1);
    send_random(90, 1'b1, 1'b1, 50);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_modes();
    test_config_extremes();
    test_random_cold();
    test_business_mode();
    test_shutdown();
    repeat (10) @(posedge clk_i);
    $display("%0d events and %0d results checked across directed, cold, business and",
             events_sent, results_seen);
    $display("shutdown phases: %0d mode changes, %0d power-offs, %0d cpu resets",
             mode_requests, poweroff_requests, cpu_resets);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS power_switch_mode_supervisor");
    end else begin
      $display("FAIL power_switch_mode_supervisor");
    end
    $finish;
  end

endmodule
